@@ rtl/core/srv_pkg.sv @@
// Shared widths, reset values, codes and control types of the Schroeder reverb.
`timescale 1ns / 1ps

package srv_pkg;

   // Sample and internal number formats
   localparam int SAMPLE_BITS = 24;              // Q1.23 in and out
   localparam int INT_BITS    = SAMPLE_BITS + 4; // Q5.23 inside
   localparam int DELAY_BITS  = 13;
   localparam int GAIN_BITS   = 15;              // unsigned Q0.15
   localparam int PROD_BITS   = INT_BITS + 1 + GAIN_BITS + 1;
   localparam int ADD_BITS    = INT_BITS + 3;

   // Structure
   localparam int N_COMBS     = 4;
   localparam int N_APS       = 3;
   localparam int STAGE_BITS  = 3;
   localparam logic [STAGE_BITS-1:0] STAGE_COMB_LAST = STAGE_BITS'(N_COMBS - 1);
   localparam logic [STAGE_BITS-1:0] STAGE_LAST      = STAGE_BITS'(N_COMBS + N_APS - 1);

   // Ring lengths (defaults of the top-level parameters)
   localparam int COMB_LEN_DEFAULT      = 4800;
   localparam int AP_LEN_FIRST_DEFAULT  = 4800;
   localparam int AP_LEN_SECOND_DEFAULT = 1600;
   localparam int AP_LEN_THIRD_DEFAULT  = 534;

   // Reset delays: ceil(ms * SAMPLE_RATE / 1000)
   localparam int SAMPLE_RATE = 48000;
   localparam logic [DELAY_BITS-1:0] DELAY_RESET_A =
      DELAY_BITS'((30 * SAMPLE_RATE + 999) / 1000);
   localparam logic [DELAY_BITS-1:0] DELAY_RESET_B =
      DELAY_BITS'((32 * SAMPLE_RATE + 999) / 1000);
   localparam logic [DELAY_BITS-1:0] DELAY_RESET_C =
      DELAY_BITS'((36 * SAMPLE_RATE + 999) / 1000);
   localparam logic [DELAY_BITS-1:0] DELAY_RESET_D =
      DELAY_BITS'((33 * SAMPLE_RATE + 999) / 1000);
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET    = GAIN_BITS'(22938);

   // Register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = GAIN_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COMB_DELAY_A = 3'd0,
      CSR_COMB_DELAY_B = 3'd1,
      CSR_COMB_DELAY_C = 3'd2,
      CSR_COMB_DELAY_D = 3'd3,
      CSR_COMB_GAIN    = 3'd4,
      CSR_ALLPASS_GAIN = 3'd5
   } srv_csr_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_MUL,
      S_ADD
   } srv_state_type;

   // Sequencer to multiply-accumulate unit
   typedef struct packed {
      logic load;       // new word taken in
      logic mul;        // register the product
      logic add;        // add, saturate, write back
      logic ap;         // current stage is an allpass
      logic comb_last;  // current stage is the last comb
      logic last;       // current stage is the last allpass
   } srv_mac_ctl_type;

endpackage

@@ rtl/core/srv_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module srv_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/srv_mac.sv @@
// Shared multiply-accumulate unit: gain products, rounding, saturation and comb sum.
`timescale 1ns / 1ps

module srv_mac (
   input  logic                                     clock,
   input  srv_pkg::srv_mac_ctl_type                 ctl,
   input  logic signed [srv_pkg::SAMPLE_BITS-1:0]   in_sample,
   input  logic [srv_pkg::INT_BITS-1:0]             comb_rd,
   input  logic [2*srv_pkg::INT_BITS-1:0]           ap_rd,
   input  logic [srv_pkg::GAIN_BITS-1:0]            comb_gain,
   input  logic [srv_pkg::GAIN_BITS-1:0]            ap_gain,
   output logic signed [srv_pkg::INT_BITS-1:0]      y,
   output logic signed [srv_pkg::INT_BITS-1:0]      chain,
   output logic signed [srv_pkg::SAMPLE_BITS-1:0]   out_sample
);

   localparam int IB = srv_pkg::INT_BITS;
   localparam int SB = srv_pkg::SAMPLE_BITS;
   localparam int GB = srv_pkg::GAIN_BITS;
   localparam int PB = srv_pkg::PROD_BITS;
   localparam int AB = srv_pkg::ADD_BITS;

   localparam logic signed [AB-1:0] INT_MAX = {{(AB-IB+1){1'b0}}, {(IB-1){1'b1}}};
   localparam logic signed [AB-1:0] INT_MIN = ~INT_MAX;
   localparam logic signed [IB-1:0] OUT_MAX = {{(IB-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [IB-1:0] OUT_MIN = ~OUT_MAX;
   localparam logic signed [PB-1:0] RND_HALF = {{(PB-GB){1'b0}}, 1'b1, {(GB-1){1'b0}}};

   function automatic logic signed [IB-1:0] sat_int(input logic signed [AB-1:0] v);
      logic signed [IB-1:0] r;
      if (v > INT_MAX) begin
         r = INT_MAX[IB-1:0];
      end else if (v < INT_MIN) begin
         r = INT_MIN[IB-1:0];
      end else begin
         r = v[IB-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SB-1:0] sat_out(input logic signed [IB-1:0] v);
      logic signed [SB-1:0] r;
      if (v > OUT_MAX) begin
         r = OUT_MAX[SB-1:0];
      end else if (v < OUT_MIN) begin
         r = OUT_MIN[SB-1:0];
      end else begin
         r = v[SB-1:0];
      end
      return r;
   endfunction

   logic signed [IB-1:0]   xin_ff;
   logic signed [IB-1:0]   chain_ff;
   logic signed [IB+1:0]   sum_ff;
   logic signed [PB-1:0]   prod_ff;
   logic signed [PB-1:0]   prod_in;

   logic signed [IB-1:0]   ap_in_word;
   logic signed [IB-1:0]   ap_out_word;
   logic signed [IB:0]     mul_a;
   logic signed [GB:0]     mul_g;
   logic signed [PB-1:0]   rnd_full;
   logic signed [IB-1:0]   addend;
   logic signed [AB-1:0]   add_sum;
   logic signed [AB-1:0]   comb_total;

   // Operand select and product
   always_comb begin
      ap_in_word  = ap_rd[2*IB-1:IB];
      ap_out_word = ap_rd[IB-1:0];
      if (ctl.ap) begin
         mul_a = {ap_out_word[IB-1], ap_out_word} - {chain_ff[IB-1], chain_ff};
         mul_g = {1'b0, ap_gain};
      end else begin
         mul_a = {comb_rd[IB-1], comb_rd};
         mul_g = {1'b0, comb_gain};
      end
      prod_in = mul_a * mul_g;
   end

   // Round to nearest (half up), add and saturate
   always_comb begin
      rnd_full   = (prod_ff + RND_HALF) >>> GB;
      addend     = ctl.ap ? ap_in_word : xin_ff;
      add_sum    = {{(AB-IB){addend[IB-1]}}, addend} + rnd_full[AB-1:0];
      y          = sat_int(add_sum);
      comb_total = {sum_ff[IB+1], sum_ff} + {{(AB-IB){y[IB-1]}}, y};
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         xin_ff <= {{(IB-SB){in_sample[SB-1]}}, in_sample};
         sum_ff <= '0;
      end
      if (ctl.mul) begin
         prod_ff <= prod_in;
      end
      if (ctl.add) begin
         if (ctl.ap) begin
            chain_ff <= y;
         end else begin
            sum_ff <= comb_total[IB+1:0];
            if (ctl.comb_last) begin
               chain_ff <= sat_int(comb_total);
            end
         end
      end
   end

   assign chain      = chain_ff;
   assign out_sample = sat_out(y);

endmodule

@@ rtl/core/srv_seq.sv @@
// Sequencer: clearing pass, per-word stage walk, ring indices and memory addresses.
`timescale 1ns / 1ps

module srv_seq #(
   parameter int COMB_LEN      = srv_pkg::COMB_LEN_DEFAULT,
   parameter int AP_LEN_FIRST  = srv_pkg::AP_LEN_FIRST_DEFAULT,
   parameter int AP_LEN_SECOND = srv_pkg::AP_LEN_SECOND_DEFAULT,
   parameter int AP_LEN_THIRD  = srv_pkg::AP_LEN_THIRD_DEFAULT
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  req_valid,
   output logic                                                  req_ready,
   input  logic                                                  out_free,
   input  logic [srv_pkg::N_COMBS-1:0][srv_pkg::DELAY_BITS-1:0]  comb_delays,
   output srv_pkg::srv_mac_ctl_type                              ctl,
   output logic                                                  clearing,
   output logic                                                  comb_wr_en,
   output logic [$clog2(srv_pkg::N_COMBS*COMB_LEN)-1:0]          comb_wr_addr,
   output logic                                                  comb_rd_en,
   output logic [$clog2(srv_pkg::N_COMBS*COMB_LEN)-1:0]          comb_rd_addr,
   output logic                                                  ap_wr_en,
   output logic [$clog2(AP_LEN_FIRST+AP_LEN_SECOND+AP_LEN_THIRD)-1:0] ap_wr_addr,
   output logic                                                  ap_rd_en,
   output logic [$clog2(AP_LEN_FIRST+AP_LEN_SECOND+AP_LEN_THIRD)-1:0] ap_rd_addr
);

   localparam int NC        = srv_pkg::N_COMBS;
   localparam int NA        = srv_pkg::N_APS;
   localparam int STB       = srv_pkg::STAGE_BITS;
   localparam int CIW       = $clog2(COMB_LEN);
   localparam int CAW       = $clog2(NC * COMB_LEN);
   localparam int AP_TOTAL  = AP_LEN_FIRST + AP_LEN_SECOND + AP_LEN_THIRD;
   localparam int AAW       = $clog2(AP_TOTAL);
   localparam int CLR_DEPTH = (NC * COMB_LEN > AP_TOTAL) ? NC * COMB_LEN : AP_TOTAL;
   localparam int CLW       = $clog2(CLR_DEPTH);
   localparam int DCW       = ((CIW > srv_pkg::DELAY_BITS) ? CIW : srv_pkg::DELAY_BITS) + 1;

   localparam int AP_LEN  [NA] = '{AP_LEN_FIRST, AP_LEN_SECOND, AP_LEN_THIRD};
   localparam int AP_BASE [NA] = '{0, AP_LEN_FIRST, AP_LEN_FIRST + AP_LEN_SECOND};

   // Start of each comb's ring in the shared comb memory
   function automatic logic [CAW-1:0] comb_base(input logic [1:0] c);
      logic [CAW-1:0] b;
      case (c)
         2'd0:    b = '0;
         2'd1:    b = CAW'(COMB_LEN);
         2'd2:    b = CAW'(2 * COMB_LEN);
         default: b = CAW'(3 * COMB_LEN);
      endcase
      return b;
   endfunction

   function automatic logic [AAW-1:0] ap_pick(input logic [NA-1:0][AAW-1:0] v,
                                              input logic [1:0] k);
      logic [AAW-1:0] r;
      case (k)
         2'd0:    r = v[0];
         2'd1:    r = v[1];
         default: r = v[2];
      endcase
      return r;
   endfunction

   srv_pkg::srv_state_type     state_ff, state_in;
   logic [STB-1:0]             stage_ff, stage_in;
   logic [CLW-1:0]             clr_cnt_ff, clr_cnt_in;
   logic [CIW-1:0]             w_ff, w_in;
   logic [NA-1:0][AAW-1:0]     ap_idx_ff, ap_idx_in;

   logic                       clr_done;
   logic                       stage_is_last;
   logic [CIW-1:0]             w_nxt;
   logic [1:0]                 rd_comb;
   logic [DCW-1:0]             w_ext, d_ext, r_ext;
   logic [NA-1:0][AAW-1:0]     ap_nxt;
   logic [NA-1:0][AAW-1:0]     ap_addr;
   logic [STB-1:0]             k_rd_full, k_wr_full;

   assign clr_done      = (clr_cnt_ff == CLW'(CLR_DEPTH - 1));
   assign stage_is_last = (stage_ff == srv_pkg::STAGE_LAST);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srv_pkg::S_CLEAR: begin
            if (clr_done) begin
               state_in = srv_pkg::S_IDLE;
            end
         end
         srv_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = srv_pkg::S_MUL;
            end
         end
         srv_pkg::S_MUL: begin
            state_in = srv_pkg::S_ADD;
         end
         srv_pkg::S_ADD: begin
            if (!stage_is_last) begin
               state_in = srv_pkg::S_MUL;
            end else if (out_free) begin
               state_in = srv_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = srv_pkg::S_CLEAR;
         end
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      req_ready     = 1'b0;
      clearing      = 1'b0;
      ctl.load      = 1'b0;
      ctl.mul       = 1'b0;
      ctl.add       = 1'b0;
      ctl.ap        = (stage_ff > srv_pkg::STAGE_COMB_LAST);
      ctl.comb_last = (stage_ff == srv_pkg::STAGE_COMB_LAST);
      ctl.last      = stage_is_last;
      case (state_ff)
         srv_pkg::S_CLEAR: begin
            clearing = 1'b1;
         end
         srv_pkg::S_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         srv_pkg::S_MUL: begin
            ctl.mul = 1'b1;
         end
         srv_pkg::S_ADD: begin
            ctl.add = !stage_is_last || out_free;
         end
         default: begin
            clearing = 1'b0;
         end
      endcase
   end

   // Ring index steps
   always_comb begin
      w_nxt = (w_ff == CIW'(COMB_LEN - 1)) ? '0 : w_ff + CIW'(1);
      for (int k = 0; k < NA; k++) begin
         ap_nxt[k]  = (ap_idx_ff[k] == AAW'(AP_LEN[k] - 1)) ? '0 : ap_idx_ff[k] + AAW'(1);
         ap_addr[k] = AAW'(AP_BASE[k]) + ap_nxt[k];
      end
   end

   // Comb read address: write index minus clamped delay, with wrap
   always_comb begin
      rd_comb = (state_ff == srv_pkg::S_IDLE) ? 2'd0 : stage_ff[1:0] + 2'd1;
      w_ext   = DCW'(w_ff);
      d_ext   = DCW'(comb_delays[rd_comb]);
      if (d_ext > DCW'(COMB_LEN - 1)) begin
         d_ext = DCW'(COMB_LEN - 1);
      end
      if (w_ext >= d_ext) begin
         r_ext = w_ext - d_ext;
      end else begin
         r_ext = w_ext + DCW'(COMB_LEN) - d_ext;
      end
   end

   // Memory ports
   always_comb begin
      k_rd_full = stage_ff - srv_pkg::STAGE_COMB_LAST;
      k_wr_full = stage_ff - (srv_pkg::STAGE_COMB_LAST + STB'(1));

      comb_rd_en   = ctl.load || (ctl.add && (stage_ff < srv_pkg::STAGE_COMB_LAST));
      comb_rd_addr = comb_base(rd_comb) + CAW'(r_ext[CIW-1:0]);
      ap_rd_en     = ctl.add && (stage_ff >= srv_pkg::STAGE_COMB_LAST) && !stage_is_last;
      ap_rd_addr   = ap_pick(ap_addr, k_rd_full[1:0]);

      if (clearing) begin
         comb_wr_en   = ({1'b0, clr_cnt_ff} < (CLW+1)'(NC * COMB_LEN));
         comb_wr_addr = CAW'(clr_cnt_ff);
         ap_wr_en     = ({1'b0, clr_cnt_ff} < (CLW+1)'(AP_TOTAL));
         ap_wr_addr   = AAW'(clr_cnt_ff);
      end else begin
         comb_wr_en   = ctl.add && !ctl.ap;
         comb_wr_addr = comb_base(stage_ff[1:0]) + CAW'(w_nxt);
         ap_wr_en     = ctl.add && ctl.ap;
         ap_wr_addr   = ap_pick(ap_addr, k_wr_full[1:0]);
      end
   end

   // Register updates
   always_comb begin
      stage_in   = stage_ff;
      clr_cnt_in = clr_cnt_ff;
      w_in       = w_ff;
      ap_idx_in  = ap_idx_ff;
      if (clearing && !clr_done) begin
         clr_cnt_in = clr_cnt_ff + CLW'(1);
      end
      if (ctl.load) begin
         stage_in = '0;
      end
      if (ctl.add) begin
         if (!stage_is_last) begin
            stage_in = stage_ff + STB'(1);
         end
         if (ctl.comb_last) begin
            w_in = w_nxt;
         end
         for (int k = 0; k < NA; k++) begin
            if (ctl.ap && (k_wr_full == STB'(k))) begin
               ap_idx_in[k] = ap_nxt[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= srv_pkg::S_CLEAR;
         stage_ff   <= '0;
         clr_cnt_ff <= '0;
         w_ff       <= '0;
         ap_idx_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         stage_ff   <= stage_in;
         clr_cnt_ff <= clr_cnt_in;
         w_ff       <= w_in;
         ap_idx_ff  <= ap_idx_in;
      end
   end

endmodule

@@ rtl/core/schroeder_reverb.sv @@
// Top level of the Schroeder reverb: registers, ring memories, sequencer and output word.
`timescale 1ns / 1ps

// Schroeder reverb, one Q1.23 word in and one Q1.23 word out. Four feedback combs
// sharing one gain feed three allpass stages in series; all ring state sits in two
// memories (comb rings, and allpass input/output pairs). After reset the block runs a
// clearing pass that writes zeros to every word of both memories before req_ready
// rises; register writes are taken meanwhile. Once idle, the block takes a word and
// issues the first read, then runs each of the seven stages as a multiply step and
// an add, saturate and write back step on the single shared multiply-accumulate
// unit, with each stage's ring read issued during the previous stage. The last stage
// waits until the output register is free before its write back, which loads the
// result there. A new word is taken in the idle state that follows the last write
// back, while the result waits in the output register.
// Write registers only while idle; delays above COMB_LEN-1 act as COMB_LEN-1.

module schroeder_reverb #(
   parameter int COMB_LEN      = srv_pkg::COMB_LEN_DEFAULT,
   parameter int AP_LEN_FIRST  = srv_pkg::AP_LEN_FIRST_DEFAULT,
   parameter int AP_LEN_SECOND = srv_pkg::AP_LEN_SECOND_DEFAULT,
   parameter int AP_LEN_THIRD  = srv_pkg::AP_LEN_THIRD_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [srv_pkg::SAMPLE_BITS-1:0]    req_in_sample,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [srv_pkg::SAMPLE_BITS-1:0]    rsp_out_sample,
   input  logic                                      csr_write_en,
   input  logic [srv_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [srv_pkg::CSR_DATA_BITS-1:0]         csr_wdata
);

   localparam int IB        = srv_pkg::INT_BITS;
   localparam int NC        = srv_pkg::N_COMBS;
   localparam int DB        = srv_pkg::DELAY_BITS;
   localparam int CAW       = $clog2(NC * COMB_LEN);
   localparam int AP_TOTAL  = AP_LEN_FIRST + AP_LEN_SECOND + AP_LEN_THIRD;
   localparam int AAW       = $clog2(AP_TOTAL);

   logic [NC-1:0][DB-1:0]              delay_ff;
   logic [srv_pkg::GAIN_BITS-1:0]      comb_gain_ff;
   logic [srv_pkg::GAIN_BITS-1:0]      ap_gain_ff;
   logic                               rsp_valid_ff;
   logic signed [srv_pkg::SAMPLE_BITS-1:0] rsp_sample_ff;

   srv_pkg::srv_mac_ctl_type           ctl;
   logic                               clearing;
   logic                               out_free;
   logic                               comb_wr_en, comb_rd_en, ap_wr_en, ap_rd_en;
   logic [CAW-1:0]                     comb_wr_addr, comb_rd_addr;
   logic [AAW-1:0]                     ap_wr_addr, ap_rd_addr;
   logic [IB-1:0]                      comb_wr_data, comb_rd_data;
   logic [2*IB-1:0]                    ap_wr_data, ap_rd_data;
   logic signed [IB-1:0]               mac_y, mac_chain;
   logic signed [srv_pkg::SAMPLE_BITS-1:0] mac_out;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff[0]  <= srv_pkg::DELAY_RESET_A;
         delay_ff[1]  <= srv_pkg::DELAY_RESET_B;
         delay_ff[2]  <= srv_pkg::DELAY_RESET_C;
         delay_ff[3]  <= srv_pkg::DELAY_RESET_D;
         comb_gain_ff <= srv_pkg::GAIN_RESET;
         ap_gain_ff   <= srv_pkg::GAIN_RESET;
      end else if (csr_write_en) begin
         case (srv_pkg::srv_csr_type'(csr_index))
            srv_pkg::CSR_COMB_DELAY_A: delay_ff[0]  <= csr_wdata[DB-1:0];
            srv_pkg::CSR_COMB_DELAY_B: delay_ff[1]  <= csr_wdata[DB-1:0];
            srv_pkg::CSR_COMB_DELAY_C: delay_ff[2]  <= csr_wdata[DB-1:0];
            srv_pkg::CSR_COMB_DELAY_D: delay_ff[3]  <= csr_wdata[DB-1:0];
            srv_pkg::CSR_COMB_GAIN:    comb_gain_ff <= csr_wdata;
            srv_pkg::CSR_ALLPASS_GAIN: ap_gain_ff   <= csr_wdata;
            default: begin
               // unused index: ignored
            end
         endcase
      end
   end

   // Output word register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.add && ctl.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.add && ctl.last) begin
         rsp_sample_ff <= mac_out;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;

   // Write data: zeros during the clearing pass
   assign comb_wr_data = clearing ? '0 : mac_y;
   assign ap_wr_data   = clearing ? '0 : {mac_chain, mac_y};

   srv_seq #(
      .COMB_LEN      (COMB_LEN),
      .AP_LEN_FIRST  (AP_LEN_FIRST),
      .AP_LEN_SECOND (AP_LEN_SECOND),
      .AP_LEN_THIRD  (AP_LEN_THIRD)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .out_free     (out_free),
      .comb_delays  (delay_ff),
      .ctl          (ctl),
      .clearing     (clearing),
      .comb_wr_en   (comb_wr_en),
      .comb_wr_addr (comb_wr_addr),
      .comb_rd_en   (comb_rd_en),
      .comb_rd_addr (comb_rd_addr),
      .ap_wr_en     (ap_wr_en),
      .ap_wr_addr   (ap_wr_addr),
      .ap_rd_en     (ap_rd_en),
      .ap_rd_addr   (ap_rd_addr)
   );

   srv_mac u_mac (
      .clock      (clock),
      .ctl        (ctl),
      .in_sample  (req_in_sample),
      .comb_rd    (comb_rd_data),
      .ap_rd      (ap_rd_data),
      .comb_gain  (comb_gain_ff),
      .ap_gain    (ap_gain_ff),
      .y          (mac_y),
      .chain      (mac_chain),
      .out_sample (mac_out)
   );

   // Four comb rings back to back
   srv_ram #(
      .WIDTH (IB),
      .DEPTH (NC * COMB_LEN)
   ) u_comb_ram (
      .clock   (clock),
      .wr_en   (comb_wr_en),
      .wr_addr (comb_wr_addr),
      .wr_data (comb_wr_data),
      .rd_en   (comb_rd_en),
      .rd_addr (comb_rd_addr),
      .rd_data (comb_rd_data)
   );

   // Allpass rings: past input and past output side by side
   srv_ram #(
      .WIDTH (2 * IB),
      .DEPTH (AP_TOTAL)
   ) u_ap_ram (
      .clock   (clock),
      .wr_en   (ap_wr_en),
      .wr_addr (ap_wr_addr),
      .wr_data (ap_wr_data),
      .rd_en   (ap_rd_en),
      .rd_addr (ap_rd_addr),
      .rd_data (ap_rd_data)
   );

endmodule
